### rtl/ata_block_to_taskfile_address_macros.svh
// ----------------------------------------------------------------------------
// ATA task-file address block - assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ATA_BLOCK_TO_TASKFILE_ADDRESS_MACROS_SVH
`define ATA_BLOCK_TO_TASKFILE_ADDRESS_MACROS_SVH

// same-cycle implication
`define AB2T_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AB2T_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/atab2t_pkg.sv
// ----------------------------------------------------------------------------
// ATA task-file address package
// Widths, codes and the per-stage item carried down the divider chain.
// ----------------------------------------------------------------------------
package atab2t_pkg;

  localparam int START_W    = 32;
  localparam int COUNT_W    = 16;
  localparam int BLK_W      = 29;  // CHS dividend bits (start <= disk_blocks)
  localparam int SPC_W      = 13;  // heads * sectors per track
  localparam int HC_W       = 5;
  localparam int SPT_W      = 8;
  localparam int LBA_W      = 28;
  localparam int CYL_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  localparam int N_CYL_STEPS  = BLK_W;
  localparam int N_HEAD_STEPS = HC_W;
  localparam int N_CELLS      = N_CYL_STEPS + N_HEAD_STEPS;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COUNT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_START = 3'd2;
  localparam logic [STATUS_W-1:0] ST_END   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_GEOM  = 3'd4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LBA_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEAD_CNT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPT       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DISK_BLKS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_SEL = 3'd4;

  localparam logic [BLK_W-1:0]  LBA_LIMIT    = 29'h1000_0000;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'd255;
  localparam logic [BYTE_W-1:0] DRIVE_MASTER = 8'hA0;
  localparam logic [BYTE_W-1:0] DRIVE_SLAVE  = 8'hB0;
  localparam logic [BYTE_W-1:0] LBA_FLAG     = 8'h40;

  typedef struct packed {
    logic                vld;
    logic [STATUS_W-1:0] status;
    logic [LBA_W-1:0]    lba_addr;
    logic [BYTE_W-1:0]   cnt;
    logic [SPC_W-1:0]    rem;      // partial remainder
    logic [BLK_W-1:0]    dvd;      // dividend bits still to shift in, MSB first
    logic [CYL_W-1:0]    quo;      // quotient bits, low end newest
    logic [CYL_W-1:0]    cyl;      // cylinder, parked after the first divide
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   sector_byte;
    logic [BYTE_W-1:0]   cyl_low_byte;
    logic [BYTE_W-1:0]   cyl_high_byte;
    logic [BYTE_W-1:0]   drive_head_byte;
    logic [BYTE_W-1:0]   count_byte;
  } res_t;

endpackage

### rtl/atab2t_in_if.sv
// ----------------------------------------------------------------------------
// ATA task-file address - request channel
// Start block and sector count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface atab2t_in_if;
  import atab2t_pkg::*;

  logic               valid;
  logic               ready;
  logic [START_W-1:0] first_block;
  logic [COUNT_W-1:0] block_count;

  modport source (output valid, output first_block, output block_count, input ready);
  modport sink   (input valid, input first_block, input block_count, output ready);
endinterface

### rtl/atab2t_out_if.sv
// ----------------------------------------------------------------------------
// ATA task-file address - result channel
// Status and task-file bytes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface atab2t_out_if;
  import atab2t_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   sector_byte;
  logic [BYTE_W-1:0]   cyl_low_byte;
  logic [BYTE_W-1:0]   cyl_high_byte;
  logic [BYTE_W-1:0]   drive_head_byte;
  logic [BYTE_W-1:0]   count_byte;

  modport source (output valid, output status, output sector_byte, output cyl_low_byte,
                  output cyl_high_byte, output drive_head_byte, output count_byte,
                  input ready);
  modport sink   (input valid, input status, input sector_byte, input cyl_low_byte,
                  input cyl_high_byte, input drive_head_byte, input count_byte,
                  output ready);
endinterface

### rtl/atab2t_cfg_if.sv
// ----------------------------------------------------------------------------
// ATA task-file address - configuration write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface atab2t_cfg_if;
  import atab2t_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/atab2t_cell.sv
// ----------------------------------------------------------------------------
// ATA task-file address - divider cell
// One restoring-division step: shift in a dividend bit, trial subtract,
// register the item for the next cell.
// ----------------------------------------------------------------------------
module atab2t_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [atab2t_pkg::SPC_W-1:0]   divisor,
  input  atab2t_pkg::item_t              d_in,
  output atab2t_pkg::item_t              d_out
);
  import atab2t_pkg::*;

  logic [SPC_W:0] sh;
  logic [SPC_W:0] diff;
  logic           qb;
  item_t          item_nxt;
  item_t          item_r;

  always_comb begin
    sh       = {d_in.rem, d_in.dvd[BLK_W-1]};
    diff     = sh - {1'b0, divisor};
    qb       = (sh >= {1'b0, divisor});
    item_nxt = d_in;
    item_nxt.rem = qb ? diff[SPC_W-1:0] : sh[SPC_W-1:0];
    item_nxt.dvd = {d_in.dvd[BLK_W-2:0], 1'b0};
    item_nxt.quo = {d_in.quo[CYL_W-2:0], qb};
  end

  // only the valid flag is cleared; payload just holds through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign d_out = item_r;

endmodule

### rtl/atab2t_chain.sv
// ----------------------------------------------------------------------------
// ATA task-file address - divider chain
// Cylinder divide (block / heads*sectors) followed by head divide
// (remainder / sectors), one quotient bit per cell.
// ----------------------------------------------------------------------------
module atab2t_chain (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [atab2t_pkg::SPC_W-1:0]   spc,
  input  logic [atab2t_pkg::SPT_W-1:0]   spt,
  input  atab2t_pkg::item_t              head_item,
  output atab2t_pkg::item_t              tail_item
);
  import atab2t_pkg::*;

  item_t            stg [0:N_CELLS];
  item_t            hand;
  logic [SPC_W-1:0] spt_ext;

  assign spt_ext = {{(SPC_W-SPT_W){1'b0}}, spt};
  assign stg[0]  = head_item;

  // Between the two divides: park the cylinder, and preload the remainder
  // with its upper bits. Those are below the sector count because
  // remainder < heads*sectors <= 31*sectors.
  always_comb begin
    hand     = stg[N_CYL_STEPS];
    hand.cyl = stg[N_CYL_STEPS].quo;
    hand.quo = '0;
    hand.rem = {{N_HEAD_STEPS{1'b0}}, stg[N_CYL_STEPS].rem[SPC_W-1:N_HEAD_STEPS]};
    hand.dvd = {stg[N_CYL_STEPS].rem[N_HEAD_STEPS-1:0], {(BLK_W-N_HEAD_STEPS){1'b0}}};
  end

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    if (i < N_CYL_STEPS) begin : g_cyl
      atab2t_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .divisor (spc),
        .d_in    (stg[i]),
        .d_out   (stg[i+1])
      );
    end else if (i == N_CYL_STEPS) begin : g_hand
      atab2t_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .divisor (spt_ext),
        .d_in    (hand),
        .d_out   (stg[i+1])
      );
    end else begin : g_head
      atab2t_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .divisor (spt_ext),
        .d_in    (stg[i]),
        .d_out   (stg[i+1])
      );
    end
  end

  assign tail_item = stg[N_CELLS];

endmodule

### rtl/ata_block_to_taskfile_address.sv
// ----------------------------------------------------------------------------
// ATA task-file address translation - top level
// Turns a start block and sector count into task-file bytes and a status.
// ----------------------------------------------------------------------------
// Path: a transferred request passes the 34 registered divider cells, then the output register, to result valid.
// Throughput: one request per cycle while the chain is not frozen, through the 34-cell restoring divider chain.
// A full output plus skid register freezes the chain; otherwise it keeps moving.
// Config port is always ready; writes are expected only while the block is idle.
// Reset (rst_n low, synchronous): pipeline and output emptied, config to defaults.
// ----------------------------------------------------------------------------
module ata_block_to_taskfile_address (
  input  logic         clk,
  input  logic         rst_n,
  atab2t_in_if.sink    in_chan,
  atab2t_out_if.source out_chan,
  atab2t_cfg_if.sink   cfg_chan
);
  import atab2t_pkg::*;

  // configuration registers
  logic              lba_mode_r;
  logic [HC_W-1:0]   head_cnt_r;
  logic [SPT_W-1:0]  spt_r;
  logic [BLK_W-1:0]  disk_blks_r;
  logic              drive_sel_r;

  logic [SPC_W-1:0]  spc;

  // entry
  logic [START_W:0]  end_sum;
  logic [BLK_W-1:0]  limit;
  logic [STATUS_W-1:0] entry_status;
  item_t             entry_item;
  item_t             tail_item;
  logic              pipe_en;

  // output side
  res_t              fmt;
  res_t              out_r;
  res_t              out_nxt;
  res_t              skid_r;
  res_t              skid_nxt;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic              skid_vld_r;
  logic              skid_vld_nxt;
  logic [BYTE_W-1:0] drive_code;

  // --------------------------------------------------------------------------
  // Config writes
  // --------------------------------------------------------------------------
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_mode_r  <= 1'b1;
      head_cnt_r  <= 5'd16;
      spt_r       <= 8'd63;
      disk_blks_r <= '0;
      drive_sel_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        REG_LBA_MODE:  lba_mode_r  <= cfg_chan.wr_data[0];
        REG_HEAD_CNT:  head_cnt_r  <= cfg_chan.wr_data[HC_W-1:0];
        REG_SPT:       spt_r       <= cfg_chan.wr_data[SPT_W-1:0];
        REG_DISK_BLKS: disk_blks_r <= cfg_chan.wr_data[BLK_W-1:0];
        REG_DRIVE_SEL: drive_sel_r <= cfg_chan.wr_data[0];
        default: ;  // unused indexes drop the write
      endcase
    end
  end

  // sectors per cylinder, 5x8 bits
  assign spc = {{(SPC_W-HC_W){1'b0}}, head_cnt_r} * {{(SPC_W-SPT_W){1'b0}}, spt_r};

  // --------------------------------------------------------------------------
  // Entry: range checks and status, in priority order
  // --------------------------------------------------------------------------
  assign end_sum = {1'b0, in_chan.first_block} +
                   {{(START_W+1-COUNT_W){1'b0}}, in_chan.block_count};
  assign limit   = lba_mode_r ? LBA_LIMIT : disk_blks_r;

  always_comb begin
    if (in_chan.block_count > COUNT_MAX) begin
      entry_status = ST_COUNT;
    end else if (in_chan.first_block > {{(START_W-BLK_W){1'b0}}, limit}) begin
      entry_status = ST_START;
    end else if (end_sum > {{(START_W+1-BLK_W){1'b0}}, limit}) begin
      entry_status = ST_END;
    end else if (!lba_mode_r && (head_cnt_r == '0 || spt_r == '0)) begin
      entry_status = ST_GEOM;
    end else begin
      entry_status = ST_OK;
    end
  end

  always_comb begin
    entry_item          = '0;
    entry_item.vld      = in_chan.valid;
    entry_item.status   = entry_status;
    entry_item.lba_addr = in_chan.first_block[LBA_W-1:0];
    entry_item.cnt      = in_chan.block_count[BYTE_W-1:0];
    entry_item.dvd      = in_chan.first_block[BLK_W-1:0];
  end

  // chain moves whenever the skid stage is free
  assign pipe_en       = !skid_vld_r;
  assign in_chan.ready = pipe_en;

  atab2t_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .spc       (spc),
    .spt       (spt_r),
    .head_item (entry_item),
    .tail_item (tail_item)
  );

  // --------------------------------------------------------------------------
  // Result formatting
  // --------------------------------------------------------------------------
  assign drive_code = drive_sel_r ? DRIVE_SLAVE : DRIVE_MASTER;

  always_comb begin
    fmt        = '0;
    fmt.status = tail_item.status;
    if (tail_item.status == ST_OK) begin
      fmt.count_byte = tail_item.cnt;
      if (lba_mode_r) begin
        fmt.sector_byte     = tail_item.lba_addr[7:0];
        fmt.cyl_low_byte    = tail_item.lba_addr[15:8];
        fmt.cyl_high_byte   = tail_item.lba_addr[23:16];
        fmt.drive_head_byte = drive_code | LBA_FLAG | {4'b0, tail_item.lba_addr[27:24]};
      end else begin
        // sector is 1-based; head keeps its low four bits only
        fmt.sector_byte     = tail_item.rem[BYTE_W-1:0] + 8'd1;
        fmt.cyl_low_byte    = tail_item.cyl[7:0];
        fmt.cyl_high_byte   = tail_item.cyl[15:8];
        fmt.drive_head_byte = drive_code | {4'b0, tail_item.quo[3:0]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid: the skid catches the item leaving the chain
  // while the output holds a stalled result.
  // --------------------------------------------------------------------------
  always_comb begin
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (out_chan.ready) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (tail_item.vld) begin
      if (!out_vld_r || out_chan.ready) begin
        out_nxt     = fmt;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = fmt;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.status          = out_r.status;
  assign out_chan.sector_byte     = out_r.sector_byte;
  assign out_chan.cyl_low_byte    = out_r.cyl_low_byte;
  assign out_chan.cyl_high_byte   = out_r.cyl_high_byte;
  assign out_chan.drive_head_byte = out_r.drive_head_byte;
  assign out_chan.count_byte      = out_r.count_byte;

endmodule

### rtl/atab2t_checker.sv
// ----------------------------------------------------------------------------
// ATA task-file address - port checker
// Watches the result channel for status, reject and drive-byte rules.
// ----------------------------------------------------------------------------
`include "ata_block_to_taskfile_address_macros.svh"

module atab2t_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [atab2t_pkg::STATUS_W-1:0]     status,
  input logic [atab2t_pkg::BYTE_W-1:0]       sector_byte,
  input logic [atab2t_pkg::BYTE_W-1:0]       cyl_low_byte,
  input logic [atab2t_pkg::BYTE_W-1:0]       cyl_high_byte,
  input logic [atab2t_pkg::BYTE_W-1:0]       drive_head_byte,
  input logic [atab2t_pkg::BYTE_W-1:0]       count_byte
);
  import atab2t_pkg::*;

  // stalled result stays up with the same status
  `AB2T_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "stalled result dropped")

  `AB2T_ASSERT_IMP(a_status_code, out_valid, status == ST_OK || status == ST_COUNT || status == ST_START || status == ST_END || status == ST_GEOM, "status code out of range")

  // a rejected request carries all-zero task-file bytes
  `AB2T_ASSERT_IMP(a_reject_zero, out_valid && status != ST_OK, sector_byte == '0 && cyl_low_byte == '0 && cyl_high_byte == '0 && drive_head_byte == '0 && count_byte == '0, "rejected request has nonzero bytes")

  // drive select pattern 0xA0/0xB0 always present on success
  `AB2T_ASSERT_IMP(a_drive_bits, out_valid && status == ST_OK, drive_head_byte[7] && drive_head_byte[5], "drive/head byte lost fixed bits")

endmodule

bind ata_block_to_taskfile_address atab2t_checker u_atab2t_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .status          (out_chan.status),
  .sector_byte     (out_chan.sector_byte),
  .cyl_low_byte    (out_chan.cyl_low_byte),
  .cyl_high_byte   (out_chan.cyl_high_byte),
  .drive_head_byte (out_chan.drive_head_byte),
  .count_byte      (out_chan.count_byte)
);
